>>> hdl/quaternion_arithmetic_unit_macros.svh
// Assertion macros used by the port-level checker.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define QAU_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent at the same edge.
`define QAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/qau_pkg.sv
// Package: widths, types and step functions of the quaternion arithmetic unit.
`timescale 1ns / 1ps
package qau_pkg;

    localparam int W         = 32;
    localparam int FRAC_BITS = 16;
    localparam int LANES     = 4;
    localparam int PROD_W    = 2 * W;
    localparam int SUM_W     = 2 * W + 3;
    localparam int ADD_W     = W + 1;
    localparam int SQ_W      = 2 * W;
    localparam int ROOT_W    = W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int MOD_W     = ROOT_W + 1;
    localparam int DVD_W     = W + FRAC_BITS;
    localparam int THR_W     = 16;
    localparam int LATENCY   = 2 + ROOT_W + DVD_W + 1;

    typedef logic [W-1:0]            word_t;
    typedef logic [LANES-1:0][W-1:0] quat_t;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_PROD  = 3'd2,
        OP_SCALE = 3'd3,
        OP_DIV   = 3'd4,
        OP_MOD   = 3'd5,
        OP_NORM  = 3'd6
    } op_t;

    typedef struct packed {
        op_t   op;
        quat_t a;
        word_t s;
        quat_t er;
        logic  ef;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   x;
        logic              carry;
        side_t             side;
    } sq_stage_t;

    typedef struct packed {
        logic [MOD_W-1:0]                  d;
        logic [LANES-1:0][MOD_W-1:0]       rem;
        logic [LANES-1:0][DVD_W-1:0]       dq;
        logic [MOD_W-1:0]                  mod;
        logic                              carry;
        side_t                             side;
    } dv_stage_t;

    // {flag, value}
    function automatic logic [W:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi)
            sat_word = {1'b1, 1'b0, {(W-1){1'b1}}};
        else if (v < lo)
            sat_word = {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            sat_word = {1'b0, v[W-1:0]};
    endfunction

    function automatic sq_stage_t sqrt_step(input sq_stage_t s);
        sq_stage_t        r;
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] t;
        r  = s;
        rs = {s.rem[REM_W-3:0], s.x[SQ_W-1 -: 2]};
        t  = REM_W'({s.root, 2'b01});
        r.x = {s.x[SQ_W-3:0], 2'b00};
        if (rs >= t)
        begin
            r.rem  = rs - t;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rs;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic dv_stage_t div_step(input dv_stage_t s);
        dv_stage_t      r;
        logic [MOD_W:0] rs;
        r = s;
        for (int n = 0; n < LANES; n++)
        begin
            rs = {s.rem[n], s.dq[n][DVD_W-1]};
            if (rs >= {1'b0, s.d})
            begin
                rs       = rs - {1'b0, s.d};
                r.dq[n]  = {s.dq[n][DVD_W-2:0], 1'b1};
            end
            else
            begin
                r.dq[n]  = {s.dq[n][DVD_W-2:0], 1'b0};
            end
            r.rem[n] = rs[MOD_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/qau_mult.sv
// Multiply and sum stages: products, add/sub, scale, sum of squares.
`timescale 1ns / 1ps
module qau_mult (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qau_pkg::op_t        in_op,
    input  qau_pkg::quat_t      in_a,
    input  qau_pkg::quat_t      in_b,
    input  qau_pkg::word_t      in_s,
    output logic                out_valid,
    output qau_pkg::side_t      out_side,
    output logic [qau_pkg::SQ_W-1:0] out_sq,
    output logic                out_carry
);
    import qau_pkg::*;

    logic                    va_reg;
    op_t                     op_reg;
    quat_t                   a_reg;
    word_t                   s_reg;
    logic signed [PROD_W-1:0] p_reg [LANES][LANES];
    logic signed [PROD_W-1:0] ps_reg [LANES];
    logic signed [PROD_W-1:0] q_reg [LANES];
    logic signed [ADD_W-1:0]  as_reg [LANES];

    logic                    vb_reg;
    side_t                   side_reg;
    logic [SQ_W+1:0]         sq_reg;

    logic signed [SUM_W-1:0] h [LANES];
    logic signed [SUM_W-1:0] v;
    logic [W:0]              sw;
    side_t                   side_next;
    logic [SQ_W+1:0]         sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= in_op;
        a_reg  <= in_a;
        s_reg  <= in_s;
        for (int n = 0; n < LANES; n++)
        begin
            for (int m = 0; m < LANES; m++)
                p_reg[n][m] <= $signed(in_a[n]) * $signed(in_b[m]);
            ps_reg[n] <= $signed(in_a[n]) * $signed(in_s);
            q_reg[n]  <= $signed(in_a[n]) * $signed(in_a[n]);
            if (in_op == OP_SUB)
                as_reg[n] <= $signed({in_a[n][W-1], in_a[n]}) - $signed({in_b[n][W-1], in_b[n]});
            else
                as_reg[n] <= $signed({in_a[n][W-1], in_a[n]}) + $signed({in_b[n][W-1], in_b[n]});
        end
        side_reg <= side_next;
        sq_reg   <= sq_next;
    end

    always_comb
    begin
        h[0] = SUM_W'(p_reg[0][0]) - SUM_W'(p_reg[1][1]) - SUM_W'(p_reg[2][2])
             - SUM_W'(p_reg[3][3]);
        h[1] = SUM_W'(p_reg[0][1]) + SUM_W'(p_reg[1][0]) + SUM_W'(p_reg[2][3])
             - SUM_W'(p_reg[3][2]);
        h[2] = SUM_W'(p_reg[0][2]) - SUM_W'(p_reg[1][3]) + SUM_W'(p_reg[2][0])
             + SUM_W'(p_reg[3][1]);
        h[3] = SUM_W'(p_reg[0][3]) + SUM_W'(p_reg[1][2]) - SUM_W'(p_reg[2][1])
             + SUM_W'(p_reg[3][0]);
        side_next.op = op_reg;
        side_next.a  = a_reg;
        side_next.s  = s_reg;
        side_next.ef = 1'b0;
        sq_next      = '0;
        for (int n = 0; n < LANES; n++)
        begin
            case (op_reg) inside
                OP_ADD, OP_SUB: v = SUM_W'(as_reg[n]);
                OP_PROD:        v = h[n] >>> FRAC_BITS;
                OP_SCALE:       v = SUM_W'(ps_reg[n]) >>> FRAC_BITS;
                default:        v = '0;
            endcase
            sw = sat_word(v);
            side_next.er[n] = sw[W-1:0];
            side_next.ef    = side_next.ef | sw[W];
            sq_next = sq_next + (SQ_W+2)'(unsigned'(q_reg[n]));
        end
    end

    assign out_valid = vb_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg[SQ_W-1:0];
    assign out_carry = |sq_reg[SQ_W+1:SQ_W];

endmodule

>>> hdl/qau_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module qau_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  qau_pkg::side_t             in_side,
    input  logic [qau_pkg::SQ_W-1:0]   in_x,
    input  logic                       in_carry,
    output logic                       out_valid,
    output qau_pkg::side_t             out_side,
    output logic [qau_pkg::ROOT_W-1:0] out_root,
    output logic                       out_carry
);
    import qau_pkg::*;

    sq_stage_t stage_reg [ROOT_W];
    logic      v_reg     [ROOT_W];
    sq_stage_t head;

    always_comb
    begin
        head.rem   = '0;
        head.root  = '0;
        head.x     = in_x;
        head.carry = in_carry;
        head.side  = in_side;
    end

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else
                    v_reg[i] <= in_valid;
            end
            always_ff @(posedge clk)
            begin
                stage_reg[i] <= sqrt_step(head);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else
                    v_reg[i] <= v_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                stage_reg[i] <= sqrt_step(stage_reg[i-1]);
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_side  = stage_reg[ROOT_W-1].side;
    assign out_root  = stage_reg[ROOT_W-1].root;
    assign out_carry = stage_reg[ROOT_W-1].carry;

endmodule

>>> hdl/qau_div.sv
// Pipelined four-lane restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qau_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  qau_pkg::side_t             in_side,
    input  logic [qau_pkg::ROOT_W-1:0] in_root,
    input  logic                       in_carry,
    output logic                       out_valid,
    output qau_pkg::dv_stage_t         out_stage
);
    import qau_pkg::*;

    dv_stage_t        stage_reg [DVD_W];
    logic             v_reg     [DVD_W];
    dv_stage_t        head;
    logic [MOD_W-1:0] s_ext;
    logic [MOD_W-1:0] a_ext;
    logic [MOD_W-1:0] a_abs;

    always_comb
    begin
        head.side  = in_side;
        head.carry = in_carry;
        head.mod   = in_carry ? {1'b1, {ROOT_W{1'b0}}} : {1'b0, in_root};
        s_ext      = {in_side.s[W-1], in_side.s};
        if (in_side.op == OP_DIV)
            head.d = in_side.s[W-1] ? -s_ext : s_ext;
        else
            head.d = head.mod;
        head.rem = '0;
        for (int n = 0; n < LANES; n++)
        begin
            a_ext       = {in_side.a[n][W-1], in_side.a[n]};
            a_abs       = in_side.a[n][W-1] ? -a_ext : a_ext;
            head.dq[n]  = {a_abs[W-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar i = 0; i < DVD_W; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else
                    v_reg[i] <= in_valid;
            end
            always_ff @(posedge clk)
            begin
                stage_reg[i] <= div_step(head);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else
                    v_reg[i] <= v_reg[i-1];
            end
            always_ff @(posedge clk)
            begin
                stage_reg[i] <= div_step(stage_reg[i-1]);
            end
        end
    end

    assign out_valid = v_reg[DVD_W-1];
    assign out_stage = stage_reg[DVD_W-1];

endmodule

>>> hdl/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit.
`timescale 1ns / 1ps
// Usage:
//   Pulse start with operation, a_*, b_*, scalar on the same cycle. busy is
//   always low, so a word is taken on every cycle that start is high.
//   Each word yields one result word: done is high for one cycle while
//   r_*, magnitude and fault hold it. The receiver cannot hold results off.
//   From start to done a word passes 2 multiply/sum stages, 32
//   square-root stages, 48 divider stages and 1 output stage. Throughput is
//   one word per cycle; every operation runs through the full pipeline so
//   results leave in order. The 48-stage divider, one quotient bit per
//   stage for the Q16.16 dividend, sets most of the latency.
//   norm_threshold is written with norm_threshold_we; write it only while
//   no word is in flight.
//   Reset (rst_n low, asynchronous) clears all valid bits and sets
//   norm_threshold to 0; words in flight are dropped.
module quaternion_arithmetic_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  operation,
    input  logic signed [31:0]          a_real,
    input  logic signed [31:0]          a_i,
    input  logic signed [31:0]          a_j,
    input  logic signed [31:0]          a_k,
    input  logic signed [31:0]          b_real,
    input  logic signed [31:0]          b_i,
    input  logic signed [31:0]          b_j,
    input  logic signed [31:0]          b_k,
    input  logic signed [31:0]          scalar,
    input  logic                        norm_threshold_we,
    input  logic [qau_pkg::THR_W-1:0]   norm_threshold,
    output logic                        done,
    output logic signed [31:0]          r_real,
    output logic signed [31:0]          r_i,
    output logic signed [31:0]          r_j,
    output logic signed [31:0]          r_k,
    output logic [31:0]                 magnitude,
    output logic                        fault
);
    import qau_pkg::*;

    logic [THR_W-1:0] thr_reg;
    quat_t            a_in;
    quat_t            b_in;

    logic             m_valid;
    side_t            m_side;
    logic [SQ_W-1:0]  m_sq;
    logic             m_carry;

    logic              s_valid;
    side_t             s_side;
    logic [ROOT_W-1:0] s_root;
    logic              s_carry;

    logic             d_valid;
    dv_stage_t        d_stage;

    logic             done_reg;
    quat_t            r_reg;
    quat_t            r_next;
    word_t            mag_reg;
    word_t            mag_next;
    logic             fault_reg;
    logic             fault_next;

    logic                    quot_path;
    logic                    neg;
    logic signed [SUM_W-1:0] qv;
    logic [W:0]              sw;

    assign busy = 1'b0;
    assign a_in = {a_k, a_j, a_i, a_real};
    assign b_in = {b_k, b_j, b_i, b_real};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (norm_threshold_we)
                thr_reg <= norm_threshold;
            done_reg <= d_valid;
        end
    end

    qau_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_op     (op_t'(operation)),
        .in_a      (a_in),
        .in_b      (b_in),
        .in_s      (scalar),
        .out_valid (m_valid),
        .out_side  (m_side),
        .out_sq    (m_sq),
        .out_carry (m_carry)
    );

    qau_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_side   (m_side),
        .in_x      (m_sq),
        .in_carry  (m_carry),
        .out_valid (s_valid),
        .out_side  (s_side),
        .out_root  (s_root),
        .out_carry (s_carry)
    );

    qau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_side   (s_side),
        .in_root   (s_root),
        .in_carry  (s_carry),
        .out_valid (d_valid),
        .out_stage (d_stage)
    );

    always_comb
    begin
        r_next     = d_stage.side.er;
        fault_next = d_stage.side.ef | d_stage.carry;
        mag_next   = d_stage.carry ? {W{1'b1}} : d_stage.mod[W-1:0];
        quot_path  = 1'b0;
        case (d_stage.side.op)
            OP_DIV:
            begin
                if (d_stage.side.s == '0)
                begin
                    fault_next = 1'b1;
                    for (int n = 0; n < LANES; n++)
                    begin
                        if (d_stage.side.a[n] == '0)
                            r_next[n] = '0;
                        else if (d_stage.side.a[n][W-1])
                            r_next[n] = {1'b1, {(W-1){1'b0}}};
                        else
                            r_next[n] = {1'b0, {(W-1){1'b1}}};
                    end
                end
                else
                    quot_path = 1'b1;
            end
            OP_NORM:
            begin
                if (d_stage.mod > MOD_W'(thr_reg))
                    quot_path = 1'b1;
                else
                    r_next = d_stage.side.a;
            end
            default:
            begin
            end
        endcase
        for (int n = 0; n < LANES; n++)
        begin
            neg = d_stage.side.a[n][W-1]
                ^ ((d_stage.side.op == OP_DIV) & d_stage.side.s[W-1]);
            qv  = SUM_W'(d_stage.dq[n]);
            if (neg)
                qv = -qv;
            sw = sat_word(qv);
            if (quot_path)
            begin
                r_next[n]  = sw[W-1:0];
                fault_next = fault_next | sw[W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg     <= r_next;
        mag_reg   <= mag_next;
        fault_reg <= fault_next;
    end

    assign done      = done_reg;
    assign r_real    = r_reg[0];
    assign r_i       = r_reg[1];
    assign r_j       = r_reg[2];
    assign r_k       = r_reg[3];
    assign magnitude = mag_reg;
    assign fault     = fault_reg;

endmodule

>>> hdl/qau_checker.sv
// Port-level checker for the quaternion arithmetic unit, with its bind.
`timescale 1ns / 1ps
`include "quaternion_arithmetic_unit_macros.svh"
module qau_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import qau_pkg::*;

    `QAU_ASSERT_ALWAYS(a_never_busy, !busy)
    `QAU_ASSERT_IMPL(a_done_has_start, done, $past(start && !busy, LATENCY))
    `QAU_ASSERT_IMPL(a_start_gives_done, start && !busy, ##LATENCY done)

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
